// File: rtl/triac_phase_angle_dimmer_macros.svh
// Assertion helpers; clk and arst_n must be visible at the point of use.
`ifndef TRIAC_PHASE_ANGLE_DIMMER_MACROS_SVH
`define TRIAC_PHASE_ANGLE_DIMMER_MACROS_SVH

// same-cycle implication
`define TPAD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPAD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tpad_pkg.sv
package tpad_pkg;

	localparam int BRIGHT_W     = 16;
	localparam int HALF_CYCLE_W = 24;
	localparam int TRIGGER_W    = 16;
	localparam int PHASE_W      = 2;
	localparam int PROD_W       = BRIGHT_W + HALF_CYCLE_W;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 24;

	localparam int QUALIFY_SAMPLES_DEF = 3;
	localparam int COUNT_WIDTH_DEF     = 24;

	localparam logic [BRIGHT_W-1:0] BRIGHT_CLAMP = 16'hFFF4;
	localparam logic [BRIGHT_W-1:0] FULL_SCALE   = 16'hFFFF;

	// trigger reset is 100 us at an 8 MHz tick
	localparam logic [HALF_CYCLE_W-1:0] HALF_CYCLE_RST = 24'd65500;
	localparam logic [TRIGGER_W-1:0]    TRIGGER_RST    = 16'd800;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_CYCLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER    = 1'd1;

	localparam logic [PHASE_W-1:0] PHASE_ARMED = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_QUAL  = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_WAIT  = 2'd2;
	localparam logic [PHASE_W-1:0] PHASE_FIRE  = 2'd3;

	typedef struct packed {
		logic cmd;
		logic level;
	} op_t;

endpackage

// File: rtl/tpad_channels.sv
interface tpad_item_if
	import tpad_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic                cmd;
	logic                zero_cross_level;
	logic [BRIGHT_W-1:0] brightness;

	modport source (output valid, cmd, zero_cross_level, brightness, input ready);
	modport sink   (input valid, cmd, zero_cross_level, brightness, output ready);
endinterface

interface tpad_result_if
	import tpad_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic               triac_drive;
	logic [PHASE_W-1:0] phase;

	modport source (output valid, triac_drive, phase, input ready);
	modport sink   (input valid, triac_drive, phase, output ready);
endinterface

interface tpad_cfg_if
	import tpad_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/tpad_delay_pipe.sv
module tpad_delay_pipe
	import tpad_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	tpad_item_if.sink               item,
	input  logic [HALF_CYCLE_W-1:0] half_cycle,
	input  logic                    take,
	output logic                    valid,
	output op_t                     op,
	output logic [COUNT_WIDTH-1:0]  delay
);

	logic                    v1_q, v2_q, v3_q;
	logic                    rdy1, rdy2, rdy3;
	op_t                     op_s1, op_s2, op_s3;
	logic [BRIGHT_W-1:0]     b_clamp;
	logic [BRIGHT_W-1:0]     diff_s1;
	logic [PROD_W-1:0]       prod_s2;
	logic [HALF_CYCLE_W-1:0] hi_s3;
	logic [HALF_CYCLE_W:0]   sum_s3;
	logic [BRIGHT_W:0]       fold;
	logic                    fold_c;
	logic [HALF_CYCLE_W-1:0] quot;

	assign rdy3       = !v3_q || take;
	assign rdy2       = !v2_q || rdy3;
	assign rdy1       = !v1_q || rdy2;
	assign item.ready = rdy1;

	assign b_clamp = (item.brightness > BRIGHT_CLAMP) ? BRIGHT_CLAMP : item.brightness;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= item.valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && rdy1) begin
			op_s1.cmd   <= item.cmd;
			op_s1.level <= item.zero_cross_level;
			diff_s1     <= FULL_SCALE - b_clamp;
		end
		if (v1_q && rdy2) begin
			op_s2   <= op_s1;
			prod_s2 <= PROD_W'(diff_s1) * PROD_W'(half_cycle);
		end
		if (v2_q && rdy3) begin
			op_s3  <= op_s2;
			hi_s3  <= prod_s2[PROD_W-1:BRIGHT_W];
			sum_s3 <= (HALF_CYCLE_W+1)'(prod_s2[PROD_W-1:BRIGHT_W])
				+ (HALF_CYCLE_W+1)'(prod_s2[BRIGHT_W-1:0]);
		end
	end

	// x / 65535 = hi + (hi + lo) / 65535, folded twice; last fold needs one compare
	assign fold   = (BRIGHT_W+1)'(sum_s3[BRIGHT_W-1:0])
		+ (BRIGHT_W+1)'(sum_s3[HALF_CYCLE_W:BRIGHT_W]);
	assign fold_c = fold >= (BRIGHT_W+1)'(FULL_SCALE);
	assign quot   = hi_s3 + HALF_CYCLE_W'(sum_s3[HALF_CYCLE_W:BRIGHT_W])
		+ HALF_CYCLE_W'(fold_c);

	assign valid = v3_q;
	assign op    = op_s3;
	assign delay = ((quot >> COUNT_WIDTH) != '0) ? '1 : COUNT_WIDTH'(quot);

endmodule

// File: rtl/tpad_phase_ctrl.sv
module tpad_phase_ctrl
	import tpad_pkg::*;
#(
	parameter int QUALIFY_SAMPLES = QUALIFY_SAMPLES_DEF,
	parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid,
	input  op_t                    op,
	input  logic [COUNT_WIDTH-1:0] delay,
	input  logic [TRIGGER_W-1:0]   trigger_ticks,
	output logic                   take,
	tpad_result_if.source          result
);

	localparam int QCW = $clog2(QUALIFY_SAMPLES + 1);

	typedef enum logic [PHASE_W-1:0] {
		ST_ARMED = PHASE_ARMED,
		ST_QUAL  = PHASE_QUAL,
		ST_WAIT  = PHASE_WAIT,
		ST_FIRE  = PHASE_FIRE
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic                   last_q, last_n;
	logic [QCW-1:0]         qcnt_q, qcnt_n, qcnt_inc;
	logic [COUNT_WIDTH-1:0] cd_q, cd_n;
	logic [COUNT_WIDTH-1:0] dly_q, dly_n;
	logic                   gate_q, gate_n;
	logic                   res_valid_q;
	logic                   res_drive_q;
	logic [PHASE_W-1:0]     res_phase_q;
	logic                   adv;

	assign take     = !res_valid_q || result.ready;
	assign adv      = valid && take;
	assign qcnt_inc = qcnt_q + QCW'(1);

	always_comb begin
		phase_n = phase_q;
		last_n  = last_q;
		qcnt_n  = qcnt_q;
		cd_n    = cd_q;
		dly_n   = dly_q;
		gate_n  = gate_q;
		if (op.cmd) begin
			dly_n = delay;
		end else begin
			case (phase_q)
				ST_ARMED: begin
					if (op.level != last_q) begin
						last_n  = op.level;
						qcnt_n  = '0;
						phase_n = ST_QUAL;
					end
				end
				ST_QUAL: begin
					if (op.level == last_q) begin
						if (qcnt_inc >= QCW'(QUALIFY_SAMPLES)) begin
							qcnt_n  = '0;
							gate_n  = 1'b0;
							cd_n    = dly_q;
							phase_n = ST_WAIT;
						end else begin
							qcnt_n = qcnt_inc;
						end
					end else begin
						// broken qualification re-arms on the new level
						last_n  = op.level;
						qcnt_n  = '0;
						phase_n = ST_ARMED;
					end
				end
				ST_WAIT: begin
					last_n = op.level;
					if (cd_q > COUNT_WIDTH'(1)) begin
						cd_n = cd_q - COUNT_WIDTH'(1);
					end else begin
						gate_n  = 1'b1;
						cd_n    = COUNT_WIDTH'(trigger_ticks);
						phase_n = ST_FIRE;
					end
				end
				ST_FIRE: begin
					last_n = op.level;
					if (cd_q > COUNT_WIDTH'(1)) begin
						cd_n = cd_q - COUNT_WIDTH'(1);
					end else begin
						gate_n  = 1'b0;
						cd_n    = '0;
						phase_n = ST_ARMED;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ST_ARMED;
			last_q      <= 1'b0;
			qcnt_q      <= '0;
			cd_q        <= '0;
			dly_q       <= '0;
			gate_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_drive_q <= 1'b0;
			res_phase_q <= PHASE_ARMED;
		end else if (adv) begin
			phase_q     <= phase_n;
			last_q      <= last_n;
			qcnt_q      <= qcnt_n;
			cd_q        <= cd_n;
			dly_q       <= dly_n;
			gate_q      <= gate_n;
			res_valid_q <= 1'b1;
			res_drive_q <= gate_n;
			res_phase_q <= phase_n;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.triac_drive = res_drive_q;
	assign result.phase       = res_phase_q;

endmodule

// File: rtl/triac_phase_angle_dimmer.sv
// Pipeline: an accepted word passes 4 register stages (s1, s2, s3 and the result register).
// Throughput: one word per cycle while results are taken; a bubble in the pipe lets a word in while
// the output word is stalled.
// Reset (arst_n low, asynchronous): pipe empty, dimmer armed with gate low,
// stored delay 0, half_cycle 65500, trigger_ticks 800. No clearing pass.
`include "triac_phase_angle_dimmer_macros.svh"

module triac_phase_angle_dimmer
	import tpad_pkg::*;
#(
	parameter int QUALIFY_SAMPLES = QUALIFY_SAMPLES_DEF,
	parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tpad_cfg_if.sink      cfg,
	tpad_item_if.sink     item,
	tpad_result_if.source result
);

	logic [HALF_CYCLE_W-1:0] half_cycle_q;
	logic [TRIGGER_W-1:0]    trigger_q;
	logic                    pipe_valid;
	logic                    pipe_take;
	op_t                     pipe_op;
	logic [COUNT_WIDTH-1:0]  pipe_delay;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_cycle_q <= HALF_CYCLE_RST;
			trigger_q    <= TRIGGER_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_HALF_CYCLE: half_cycle_q <= cfg.data;
				CFG_TRIGGER:    trigger_q    <= cfg.data[TRIGGER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tpad_delay_pipe #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_delay_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.half_cycle(half_cycle_q),
		.take      (pipe_take),
		.valid     (pipe_valid),
		.op        (pipe_op),
		.delay     (pipe_delay)
	);

	tpad_phase_ctrl #(
		.QUALIFY_SAMPLES(QUALIFY_SAMPLES),
		.COUNT_WIDTH    (COUNT_WIDTH)
	) u_phase_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (pipe_valid),
		.op           (pipe_op),
		.delay        (pipe_delay),
		.trigger_ticks(trigger_q),
		.take         (pipe_take),
		.result       (result)
	);

	// gate is high exactly while firing
	`TPAD_ASSERT_NOW(a_gate_phase, result.valid,
		result.triac_drive == (result.phase == PHASE_FIRE), "gate level disagrees with phase")
	// input stalls only when the whole pipe is full behind a stalled output
	`TPAD_ASSERT_NOW(a_stall_full, !item.ready,
		result.valid && !result.ready && pipe_valid, "input stalled with a bubble in the pipe")
	// an idle pipe with no input drains its output once taken
	`TPAD_ASSERT_NEXT(a_drain, result.valid && result.ready && !pipe_valid,
		!result.valid, "result repeated after it was taken")

endmodule

// File: verif/triac_phase_angle_dimmer_tb.sv
module triac_phase_angle_dimmer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tpad_pkg::*;

	localparam int COUNT_W = COUNT_WIDTH_DEF;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	typedef struct packed {
		logic               drive;
		logic [PHASE_W-1:0] phase;
	} gate_phase_t;

	logic clk = 1'b0;
	logic arst_n;

	tpad_cfg_if    cfg_ch();
	tpad_item_if   item_ch();
	tpad_result_if result_ch();

	triac_phase_angle_dimmer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// dimmer state as the block should hold it after each accepted word
	logic [PHASE_W-1:0]      dim_phase;
	logic                    dim_last;
	int                      dim_qual;
	logic [COUNT_W-1:0]      dim_count;
	logic [COUNT_W-1:0]      dim_delay;
	logic                    dim_gate;
	logic [HALF_CYCLE_W-1:0] hc_setting;
	logic [TRIGGER_W-1:0]    trig_setting;

	gate_phase_t gate_phase_q[$];
	int          errors;
	int          n_checked;
	int          send_idle_pct;
	int          recv_stall_pct;

	function automatic gate_phase_t predict_gate_phase(input logic c, input logic lvl,
			input logic [BRIGHT_W-1:0] b);
		logic [BRIGHT_W-1:0] bc;
		logic [PROD_W-1:0]   dly;
		gate_phase_t         r;
		if (c == CMD_SET) begin
			bc = (b > BRIGHT_CLAMP) ? BRIGHT_CLAMP : b;
			dly = (PROD_W'(FULL_SCALE - bc) * PROD_W'(hc_setting)) / PROD_W'(FULL_SCALE);
			// cannot exceed the count range at 24 bits, kept for wider products
			dim_delay = (dly > PROD_W'(COUNT_MAX)) ? COUNT_MAX : dly[COUNT_W-1:0];
		end else begin
			case (dim_phase)
			PHASE_ARMED: begin
				if (lvl != dim_last) begin
					dim_last = lvl;
					dim_qual = 0;
					dim_phase = PHASE_QUAL;
				end
			end
			PHASE_QUAL: begin
				if (lvl == dim_last) begin
					dim_qual++;
					if (dim_qual >= QUALIFY_SAMPLES_DEF) begin
						dim_qual = 0;
						dim_gate = 1'b0;
						dim_count = dim_delay;
						dim_phase = PHASE_WAIT;
					end
				end else begin
					dim_last = lvl;
					dim_qual = 0;
					dim_phase = PHASE_ARMED;
				end
			end
			PHASE_WAIT: begin
				dim_last = lvl;
				if (dim_count > 1) begin
					dim_count--;
				end else begin
					dim_gate = 1'b1;
					dim_count = COUNT_W'(trig_setting);
					dim_phase = PHASE_FIRE;
				end
			end
			default: begin
				dim_last = lvl;
				if (dim_count > 1) begin
					dim_count--;
				end else begin
					dim_gate = 1'b0;
					dim_count = '0;
					dim_phase = PHASE_ARMED;
				end
			end
			endcase
		end
		r.drive = dim_gate;
		r.phase = dim_phase;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at result word %0d: %s", n_checked, what);
		errors++;
	endtask

	always @(posedge clk) begin
		gate_phase_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (gate_phase_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word drive=%0b phase=%0d",
					result_ch.triac_drive, result_ch.phase));
			end else begin
				want = gate_phase_q.pop_front();
				if (result_ch.triac_drive !== want.drive)
					report_mismatch($sformatf("triac_drive %0b, expected %0b",
						result_ch.triac_drive, want.drive));
				if (result_ch.phase !== want.phase)
					report_mismatch($sformatf("phase %0d, expected %0d",
						result_ch.phase, want.phase));
			end
			n_checked++;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_word(input logic c, input logic lvl, input logic [BRIGHT_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd <= c;
		item_ch.zero_cross_level <= lvl;
		item_ch.brightness <= b;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		gate_phase_q.push_back(predict_gate_phase(c, lvl, b));
	endtask

	// brightness and level are don't-care on the other command, so keep them moving
	task automatic tick(input logic lvl);
		send_word(CMD_TICK, lvl, BRIGHT_W'($urandom_range(0, 65535)));
	endtask

	task automatic set_bright(input logic [BRIGHT_W-1:0] b);
		send_word(CMD_SET, 1'($urandom_range(1)), b);
	endtask

	task automatic qualify_edge();
		tick(!dim_last);
		repeat (QUALIFY_SAMPLES_DEF)
			tick(dim_last);
	endtask

	// steady pin until the dimmer is armed again
	task automatic park_armed();
		while (dim_phase != PHASE_ARMED)
			tick(dim_last);
	endtask

	// an empty queue means valid is already low
	task automatic drain_results();
		if (gate_phase_q.size() != 0) begin
			item_ch.valid <= 1'b0;
			while (gate_phase_q.size() != 0)
				@(posedge clk);
		end
	endtask

	task automatic configure(input logic [HALF_CYCLE_W-1:0] hc, input logic [TRIGGER_W-1:0] trig);
		park_armed();
		drain_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_HALF_CYCLE;
		cfg_ch.data <= CFG_DATA_W'(hc);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		hc_setting = hc;
		cfg_ch.index <= CFG_TRIGGER;
		cfg_ch.data <= CFG_DATA_W'(trig);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		trig_setting = trig;
		cfg_ch.valid <= 1'b0;
	endtask

	// reset values: no firing at the default 800-tick trigger, only failed qualifications
	task automatic test_reset_state();
		tick(1'b0);
		set_bright(16'h0000);
		tick(1'b1);
		tick(1'b0);
		tick(1'b1);
		tick(1'b1);
		tick(1'b0);
	endtask

	task automatic test_directed();
		configure(24'd6, 16'd0);
		set_bright(16'hFFFF);
		set_bright(16'hFFF5);
		qualify_edge();
		tick(dim_last);
		tick(!dim_last);
		set_bright(16'd50000);
		qualify_edge();
		tick(dim_last);
		tick(dim_last);
		tick(!dim_last);
		set_bright(16'h0000);
		repeat (QUALIFY_SAMPLES_DEF)
			tick(dim_last);
		// edges during the wait and the pulse are ignored
		repeat (7)
			tick(!dim_last);
		set_bright(16'hFFF4);
		set_bright(16'h8000);
	endtask

	// large half cycle with a short wait, then zero half cycle with a short pulse
	task automatic test_extremes();
		configure(24'h03FFFF, 16'd1);
		set_bright(16'h0000);
		set_bright(16'hFFFF);
		qualify_edge();
		park_armed();
		configure(24'd0, 16'd2);
		set_bright(16'h0000);
		qualify_edge();
		park_armed();
	endtask

	task automatic test_random(input int n_sets, input int per_set, input bit hold_once);
		logic                    lvl;
		int                      run_left;
		logic [HALF_CYCLE_W-1:0] hc;
		logic [TRIGGER_W-1:0]    trig;
		logic [BRIGHT_W-1:0]     b;
		for (int s = 0; s < n_sets; s++) begin
			if ($urandom_range(4) == 0)
				hc = HALF_CYCLE_W'($urandom_range(61, 500));
			else
				hc = HALF_CYCLE_W'($urandom_range(0, 60));
			if ($urandom_range(9) == 0)
				trig = '0;
			else if ($urandom_range(9) == 0)
				trig = TRIGGER_W'($urandom_range(25, 300));
			else
				trig = TRIGGER_W'($urandom_range(1, 24));
			configure(hc, trig);
			lvl = dim_last;
			run_left = 0;
			for (int k = 0; k < per_set; k++) begin
				if ((hold_once && s == 0 && k == per_set / 2) || $urandom_range(149) == 0)
					drain_results();
				if ($urandom_range(15) == 0) begin
					if ($urandom_range(3) == 0)
						b = BRIGHT_W'($urandom_range(16'hFFF0, 16'hFFFF));
					else
						b = BRIGHT_W'($urandom_range(0, 65535));
					set_bright(b);
				end else begin
					// level runs: mostly long enough to qualify, some short glitches
					if (run_left == 0) begin
						lvl = !lvl;
						if ($urandom_range(9) < 3)
							run_left = $urandom_range(1, QUALIFY_SAMPLES_DEF);
						else
							run_left = $urandom_range(QUALIFY_SAMPLES_DEF + 1, 40);
					end
					tick(lvl);
					run_left--;
				end
			end
		end
	endtask

	initial begin
		errors = 0;
		n_checked = 0;
		send_idle_pct = 16;
		recv_stall_pct = 79;
		dim_phase = PHASE_ARMED;
		dim_last = 1'b0;
		dim_qual = 0;
		dim_count = '0;
		dim_delay = '0;
		dim_gate = 1'b0;
		hc_setting = HALF_CYCLE_RST;
		trig_setting = TRIGGER_RST;
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_HALF_CYCLE;
		cfg_ch.data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.cmd <= CMD_TICK;
		item_ch.zero_cross_level <= 1'b0;
		item_ch.brightness <= '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed();
		test_random(3, 60, 1'b1);

		send_idle_pct = 79;
		recv_stall_pct = 16;
		test_random(3, 60, 1'b0);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_extremes();
		test_random(1, 60, 1'b0);

		drain_results();
		repeat (8)
			@(posedge clk);
		if (errors == 0) begin
			$display("triac_phase_angle_dimmer_tb OK");
		end else begin
			$display("triac_phase_angle_dimmer_tb NOT OK");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout, %0d result words still pending", gate_phase_q.size());
		$display("triac_phase_angle_dimmer_tb NOT OK");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/tpad_pkg.sv
rtl/tpad_channels.sv
rtl/tpad_delay_pipe.sv
rtl/tpad_phase_ctrl.sv
rtl/triac_phase_angle_dimmer.sv
verif/triac_phase_angle_dimmer_tb.sv
